/* hdl/bspline_curve_point_evaluator_unit_macros.svh */
// Assertion macros for the checker file of the curve evaluator.
// No dependencies; include by bare file name.
`ifndef BSPLINE_CURVE_POINT_EVALUATOR_UNIT_MACROS_SVH
`define BSPLINE_CURVE_POINT_EVALUATOR_UNIT_MACROS_SVH

// Same-cycle implication under asynchronous active-low reset.
`define BSPC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bspc assertion failed");

// Next-cycle implication under asynchronous active-low reset.
`define BSPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bspc assertion failed");

`endif

/* hdl/bspc_pkg.sv */
// Shared widths, codes and types for the B-spline curve point evaluator.
// No dependencies.
package bspc_pkg;

	localparam int ACTION_W   = 2;
	localparam int SLOT_W     = 7;
	localparam int KNOT_W     = 17;
	localparam int PARAM_W    = 17;
	localparam int COORD_W    = 32;
	localparam int SPAN_W     = 7;
	localparam int DEGREE_W   = 2;
	localparam int LAST_W     = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;
	// knot minus parameter, both unsigned Q1.16, as a signed value
	localparam int LR_W       = KNOT_W + 2;

	localparam logic [ACTION_W-1:0] ACT_LOAD_KNOT  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_LOAD_POINT = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_EVAL       = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_DEGREE     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LAST_POINT = 2'd1;

	localparam logic [DEGREE_W-1:0] DEGREE_RST = 2'd3;
	localparam logic [LAST_W-1:0]   LAST_RST   = 6'd3;

	typedef logic [ACTION_W-1:0]        action_t;
	typedef logic [SLOT_W-1:0]          slot_t;
	typedef logic [KNOT_W-1:0]          knot_t;
	typedef logic signed [COORD_W-1:0]  coord_t;
	typedef logic [SPAN_W-1:0]          span_t;
	typedef logic [CFG_IDX_W-1:0]       cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0]      cfg_data_t;

endpackage

/* hdl/bspc_ifs.sv */
// Request channels of the B-spline curve point evaluator.
// Depends on bspc_pkg.
interface bspc_in_if;
	logic              valid;
	logic              ready;
	bspc_pkg::action_t action;
	bspc_pkg::slot_t   slot;
	bspc_pkg::knot_t   knot_value;
	bspc_pkg::coord_t  point_x;
	bspc_pkg::coord_t  point_y;
	bspc_pkg::coord_t  point_z;
	bspc_pkg::knot_t   param_t;

	modport source (output valid, action, slot, knot_value, point_x, point_y, point_z,
		param_t, input ready);
	modport sink (input valid, action, slot, knot_value, point_x, point_y, point_z,
		param_t, output ready);
endinterface

interface bspc_out_if;
	logic             valid;
	logic             ready;
	bspc_pkg::coord_t curve_x;
	bspc_pkg::coord_t curve_y;
	bspc_pkg::coord_t curve_z;
	bspc_pkg::span_t  span_index;

	modport source (output valid, curve_x, curve_y, curve_z, span_index, input ready);
	modport sink (input valid, curve_x, curve_y, curve_z, span_index, output ready);
endinterface

interface bspc_cfg_if;
	logic                valid;
	logic                ready;
	bspc_pkg::cfg_idx_t  index;
	bspc_pkg::cfg_data_t data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hdl/bspc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bspc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* hdl/bspline_curve_point_evaluator_unit.sv */
// B-spline curve point evaluator: knot span search, Cox-de Boor basis, weighted sum.
// Evaluate requests run through the shared restoring divider, one quotient bit per cycle.
// Load requests write the stores directly from idle; one request is in work at a time.
// Reset (arst_n low, asynchronous) returns to idle, degree 3, last point 3.
module bspline_curve_point_evaluator_unit #(
	parameter int MAX_POINTS = 64,
	parameter int MAX_DEGREE = 3,
	parameter int FRAC_BITS  = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	bspc_in_if.sink     in_ch,
	bspc_out_if.source  out_ch,
	bspc_cfg_if.sink    cfg_ch
);

	// Store and index sizes
	localparam int KNOT_DEPTH = MAX_POINTS + MAX_DEGREE + 1;
	localparam int KA  = $clog2(KNOT_DEPTH);
	localparam int PA  = $clog2(MAX_POINTS);
	localparam int IW  = $clog2(KNOT_DEPTH + MAX_DEGREE + 1);
	localparam int DW  = $clog2(MAX_DEGREE + 1);
	localparam int JW  = $clog2(MAX_DEGREE + 2);
	// Datapath widths: basis values, quotient, product, denominator, accumulator
	localparam int BW  = FRAC_BITS + 6;
	localparam int QW  = BW;
	localparam int PW  = bspc_pkg::COORD_W + BW;
	localparam int DNW = bspc_pkg::LR_W + 1;
	localparam int AW  = PW + 3;
	localparam int CW  = $clog2(QW);
	localparam int LRW = bspc_pkg::LR_W;
	localparam int CRW = bspc_pkg::COORD_W;
	localparam logic signed [BW+1:0] LIM = (BW+2)'(1) << (FRAC_BITS + 4);

	typedef enum logic [4:0] {
		ST_IDLE, ST_SRCH, ST_SCMP, ST_KL, ST_KR, ST_KC,
		ST_RDEN, ST_RMUL, ST_RDST, ST_RDIV, ST_RUPD,
		ST_PRD, ST_PMX, ST_PMY, ST_PMZ, ST_PACC, ST_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   fin_go_c;

	// Configuration
	logic [bspc_pkg::DEGREE_W-1:0] degree_q;
	logic [bspc_pkg::LAST_W-1:0]   last_q;
	logic [DW-1:0]                 d_c;
	logic [IW-1:0]                 last_c;

	// Search and index state
	logic [bspc_pkg::PARAM_W-1:0] t_q;
	logic [IW-1:0] low_q, high_q, mid_q, span_q;
	logic [IW-1:0] mid_c, kl_idx_c, kr_idx_c, k_c;
	logic          srch_more_c;
	logic [JW-1:0] j_q, r_q, i_q;
	logic [JW-1:0] r1_c, jr_c;
	logic          kv_q, pv_q;

	// Recurrence state
	logic signed [LRW-1:0] left_q  [MAX_DEGREE+1];
	logic signed [LRW-1:0] right_q [MAX_DEGREE+1];
	logic signed [BW-1:0]  basis_q [MAX_DEGREE+1];
	logic signed [BW-1:0]  saved_q;
	logic signed [BW:0]    a_q, b_q;
	logic signed [DNW-1:0] den_q, den_c;
	logic                  sel_b_q;

	// Shared multiplier and divider
	logic signed [CRW-1:0] mul_a_c;
	logic signed [BW-1:0]  mul_b_c;
	logic signed [PW-1:0]  prod_c, prod_q;
	logic [PW-1:0]         nmag_c;
	logic [DNW-1:0]        dmag_c, dmag_q, rem_q, rem_n_c;
	logic [DNW:0]          shl_c;
	logic                  ge_c, ovf_c, dneg_c, dneg_q, fin_neg_c;
	logic [QW-1:0]         quo_q, quo_n_c, fin_quo_c;
	logic [CW-1:0]         dcnt_q;
	logic signed [QW:0]    div_res_c;

	// Basis update
	logic signed [BW+1:0] sum_c, bx_c;
	logic signed [BW-1:0] new_basis_c, new_saved_c;

	// Point sum
	logic [3*CRW-1:0]      pt_q;
	logic signed [AW-1:0]  acc_x_q, acc_y_q, acc_z_q, prod_ext_c;

	// Stores
	logic                  knot_we_c, ctrl_we_c;
	logic [KA-1:0]         knot_raddr_c;
	logic [bspc_pkg::KNOT_W-1:0] knot_rdata, knot_rd_c;
	logic [3*CRW-1:0]      ctrl_rdata;
	logic                  in_acc_c;

	function automatic logic [CRW-1:0] fin_coord(input logic signed [AW-1:0] acc);
		logic          neg;
		logic [AW-1:0] mag;
		logic [AW-1:0] rnd;
		neg = acc[AW-1];
		mag = neg ? AW'(-acc) : AW'(acc);
		rnd = (mag + (AW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
		if (!neg && rnd > AW'(33'h0_7fff_ffff)) begin
			return 32'h7fff_ffff;
		end else if (neg && rnd > AW'(33'h0_8000_0000)) begin
			return 32'h8000_0000;
		end else begin
			return neg ? CRW'(-rnd) : CRW'(rnd);
		end
	endfunction

	assign in_ch.ready  = (state_q == ST_IDLE);
	assign cfg_ch.ready = 1'b1;
	assign out_ch.valid = out_valid_q;
	assign in_acc_c     = in_ch.valid && in_ch.ready;

	// Hand the finished point over when the output register is free
	assign fin_go_c = (state_q == ST_FIN) && (!out_valid_q || out_ch.ready);

	// Register values beyond the store sizes act as the largest supported value
	assign d_c    = (32'(degree_q) > MAX_DEGREE) ? DW'(MAX_DEGREE) : DW'(degree_q);
	assign last_c = (32'(last_q) > MAX_POINTS - 1) ? IW'(MAX_POINTS - 1) : IW'(last_q);

	assign mid_c       = IW'(((IW+1)'(low_q) + (IW+1)'(high_q)) >> 1);
	assign srch_more_c = (IW+1)'(high_q) > ((IW+1)'(low_q) + (IW+1)'(1));
	assign kl_idx_c    = span_q + IW'(1) - IW'(j_q);
	assign kr_idx_c    = span_q + IW'(j_q);
	assign k_c         = span_q - IW'(d_c) + IW'(i_q);
	assign r1_c        = r_q + JW'(1);
	assign jr_c        = j_q - r_q;

	// Knot read address, by phase
	always_comb begin
		case (state_q)
			ST_SRCH: knot_raddr_c = KA'(mid_c);
			ST_KL:   knot_raddr_c = KA'(kl_idx_c);
			ST_KR:   knot_raddr_c = KA'(kr_idx_c);
			default: knot_raddr_c = '0;
		endcase
	end

	// Entries beyond the knot store read as zero
	assign knot_rd_c = kv_q ? knot_rdata : '0;

	assign knot_we_c = in_acc_c && (in_ch.action == bspc_pkg::ACT_LOAD_KNOT)
		&& (32'(in_ch.slot) < KNOT_DEPTH);
	assign ctrl_we_c = in_acc_c && (in_ch.action == bspc_pkg::ACT_LOAD_POINT)
		&& (32'(in_ch.slot) < MAX_POINTS);

	bspc_ram #(.WIDTH(bspc_pkg::KNOT_W), .DEPTH(KNOT_DEPTH)) u_knot_ram (
		.clk   (clk),
		.we    (knot_we_c),
		.waddr (KA'(in_ch.slot)),
		.wdata (in_ch.knot_value),
		.raddr (knot_raddr_c),
		.rdata (knot_rdata)
	);

	// Control points held as one word: z, y, x from the top down
	bspc_ram #(.WIDTH(3 * CRW), .DEPTH(MAX_POINTS)) u_ctrl_ram (
		.clk   (clk),
		.we    (ctrl_we_c),
		.waddr (PA'(in_ch.slot)),
		.wdata ({in_ch.point_z, in_ch.point_y, in_ch.point_x}),
		.raddr (PA'(k_c)),
		.rdata (ctrl_rdata)
	);

	// Shared multiplier operands
	always_comb begin
		case (state_q)
			ST_RMUL: begin
				mul_a_c = sel_b_q
					? $signed({{(CRW-LRW){left_q[jr_c[DW-1:0]][LRW-1]}},
						left_q[jr_c[DW-1:0]]})
					: $signed({{(CRW-LRW){right_q[r1_c[DW-1:0]][LRW-1]}},
						right_q[r1_c[DW-1:0]]});
				mul_b_c = basis_q[r_q[DW-1:0]];
			end
			ST_PMX: begin
				mul_a_c = $signed(ctrl_rdata[CRW-1:0]);
				mul_b_c = basis_q[i_q[DW-1:0]];
			end
			ST_PMY: begin
				mul_a_c = $signed(pt_q[2*CRW-1:CRW]);
				mul_b_c = basis_q[i_q[DW-1:0]];
			end
			ST_PMZ: begin
				mul_a_c = $signed(pt_q[3*CRW-1:2*CRW]);
				mul_b_c = basis_q[i_q[DW-1:0]];
			end
			default: begin
				mul_a_c = '0;
				mul_b_c = '0;
			end
		endcase
	end

	assign prod_c     = mul_a_c * mul_b_c;
	assign prod_ext_c = $signed({{(AW-PW){prod_q[PW-1]}}, prod_q});

	// Denominator right[r+1] + left[j-r]
	assign den_c = $signed({right_q[r1_c[DW-1:0]][LRW-1], right_q[r1_c[DW-1:0]]})
		+ $signed({left_q[jr_c[DW-1:0]][LRW-1], left_q[jr_c[DW-1:0]]});

	// Divider: magnitudes, overflow pre-check, one quotient bit per step
	assign nmag_c = prod_q[PW-1] ? PW'(-prod_q) : PW'(prod_q);
	assign dmag_c = den_q[DNW-1] ? DNW'(-den_q) : DNW'(den_q);
	assign dneg_c = prod_q[PW-1] ^ den_q[DNW-1];
	assign ovf_c  = nmag_c[PW-1:QW] >= (PW-QW)'(dmag_c);

	assign shl_c   = {rem_q, quo_q[QW-1]};
	assign ge_c    = shl_c >= {1'b0, dmag_q};
	assign rem_n_c = ge_c ? DNW'(shl_c - {1'b0, dmag_q}) : DNW'(shl_c);
	assign quo_n_c = {quo_q[QW-2:0], ge_c};

	// A quotient too large for the basis range saturates; the clamp below finishes it
	assign fin_quo_c = (state_q == ST_RDST) ? '1 : quo_n_c;
	assign fin_neg_c = (state_q == ST_RDST) ? dneg_c : dneg_q;
	assign div_res_c = fin_neg_c ? -$signed({1'b0, fin_quo_c}) : $signed({1'b0, fin_quo_c});

	// Basis update with clamping to the basis range
	assign sum_c = $signed({{2{saved_q[BW-1]}}, saved_q}) + $signed({a_q[BW], a_q});
	assign bx_c  = $signed({b_q[BW], b_q});

	always_comb begin
		if (sum_c > LIM) begin
			new_basis_c = BW'(LIM);
		end else if (sum_c < -LIM) begin
			new_basis_c = BW'(-LIM);
		end else begin
			new_basis_c = BW'(sum_c);
		end
		if (bx_c > LIM) begin
			new_saved_c = BW'(LIM);
		end else if (bx_c < -LIM) begin
			new_saved_c = BW'(-LIM);
		end else begin
			new_saved_c = BW'(bx_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			degree_q    <= bspc_pkg::DEGREE_RST;
			last_q      <= bspc_pkg::LAST_RST;
			out_valid_q <= 1'b0;
			out_ch.curve_x    <= '0;
			out_ch.curve_y    <= '0;
			out_ch.curve_z    <= '0;
			out_ch.span_index <= '0;
			t_q     <= '0;
			low_q   <= '0;
			high_q  <= '0;
			mid_q   <= '0;
			span_q  <= '0;
			j_q     <= '0;
			r_q     <= '0;
			i_q     <= '0;
			kv_q    <= 1'b0;
			pv_q    <= 1'b0;
			left_q  <= '{default: '0};
			right_q <= '{default: '0};
			basis_q <= '{default: '0};
			saved_q <= '0;
			a_q     <= '0;
			b_q     <= '0;
			den_q   <= '0;
			sel_b_q <= 1'b0;
			prod_q  <= '0;
			dmag_q  <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
			dneg_q  <= 1'b0;
			dcnt_q  <= '0;
			pt_q    <= '0;
			acc_x_q <= '0;
			acc_y_q <= '0;
			acc_z_q <= '0;
		end else begin
			prod_q <= prod_c;

			// Configuration writes must arrive only while idle; the block itself leaves this unchecked.
			if (cfg_ch.valid) begin
				case (cfg_ch.index)
					bspc_pkg::CFG_DEGREE:     degree_q <= cfg_ch.data[bspc_pkg::DEGREE_W-1:0];
					bspc_pkg::CFG_LAST_POINT: last_q   <= cfg_ch.data[bspc_pkg::LAST_W-1:0];
					default: ;
				endcase
			end

			// Raise the result when handed over, drop it once taken
			if (fin_go_c) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					// Loads write the stores directly; only evaluate leaves idle
					if (in_acc_c && in_ch.action == bspc_pkg::ACT_EVAL) begin
						t_q     <= in_ch.param_t;
						low_q   <= IW'(d_c);
						high_q  <= last_c + IW'(1);
						state_q <= ST_SRCH;
					end
				end

				// Binary span search: read knot[mid], compare next cycle
				ST_SRCH: begin
					if (srch_more_c) begin
						mid_q   <= mid_c;
						kv_q    <= 1'b1;
						state_q <= ST_SCMP;
					end else begin
						span_q  <= low_q;
						basis_q <= '{0: BW'(1) << FRAC_BITS, default: '0};
						j_q     <= JW'(1);
						i_q     <= '0;
						acc_x_q <= '0;
						acc_y_q <= '0;
						acc_z_q <= '0;
						state_q <= (d_c == '0) ? ST_PRD : ST_KL;
					end
				end
				ST_SCMP: begin
					if (t_q < knot_rd_c) begin
						high_q <= mid_q;
					end else begin
						low_q <= mid_q;
					end
					state_q <= ST_SRCH;
				end

				// Fetch left[j] and right[j] for every j up to the degree
				ST_KL: begin
					kv_q    <= 32'(kl_idx_c) < KNOT_DEPTH;
					state_q <= ST_KR;
				end
				ST_KR: begin
					left_q[j_q[DW-1:0]] <= $signed({2'b00, t_q}) - $signed({2'b00, knot_rd_c});
					kv_q    <= 32'(kr_idx_c) < KNOT_DEPTH;
					state_q <= ST_KC;
				end
				ST_KC: begin
					right_q[j_q[DW-1:0]] <= $signed({2'b00, knot_rd_c}) - $signed({2'b00, t_q});
					if (j_q == JW'(d_c)) begin
						j_q     <= JW'(1);
						r_q     <= '0;
						saved_q <= '0;
						state_q <= ST_RDEN;
					end else begin
						j_q     <= j_q + JW'(1);
						state_q <= ST_KL;
					end
				end

				// Triangular recurrence: one (j, r) step per pass
				ST_RDEN: begin
					den_q   <= den_c;
					sel_b_q <= 1'b0;
					state_q <= ST_RMUL;
				end
				ST_RMUL: begin
					if (den_q == '0) begin
						// Zero denominator: both terms vanish
						a_q     <= '0;
						b_q     <= '0;
						state_q <= ST_RUPD;
					end else begin
						state_q <= ST_RDST;
					end
				end
				ST_RDST: begin
					dmag_q <= dmag_c;
					dneg_q <= dneg_c;
					if (ovf_c) begin
						if (sel_b_q) begin
							b_q     <= div_res_c;
							state_q <= ST_RUPD;
						end else begin
							a_q     <= div_res_c;
							sel_b_q <= 1'b1;
							state_q <= ST_RMUL;
						end
					end else begin
						rem_q   <= nmag_c[QW+DNW-1:QW];
						quo_q   <= nmag_c[QW-1:0];
						dcnt_q  <= '0;
						state_q <= ST_RDIV;
					end
				end
				ST_RDIV: begin
					rem_q  <= rem_n_c;
					quo_q  <= quo_n_c;
					dcnt_q <= dcnt_q + CW'(1);
					if (dcnt_q == CW'(QW - 1)) begin
						if (sel_b_q) begin
							b_q     <= div_res_c;
							state_q <= ST_RUPD;
						end else begin
							a_q     <= div_res_c;
							sel_b_q <= 1'b1;
							state_q <= ST_RMUL;
						end
					end
				end
				ST_RUPD: begin
					basis_q[r_q[DW-1:0]] <= new_basis_c;
					if (r1_c == j_q) begin
						basis_q[j_q[DW-1:0]] <= new_saved_c;
						if (j_q == JW'(d_c)) begin
							state_q <= ST_PRD;
						end else begin
							j_q     <= j_q + JW'(1);
							r_q     <= '0;
							saved_q <= '0;
							state_q <= ST_RDEN;
						end
					end else begin
						saved_q <= new_saved_c;
						r_q     <= r1_c;
						state_q <= ST_RDEN;
					end
				end

				// Weighted sum: read point, then x, y, z through the multiplier
				ST_PRD: begin
					pv_q    <= 32'(k_c) < MAX_POINTS;
					state_q <= ST_PMX;
				end
				ST_PMX: begin
					pt_q    <= ctrl_rdata;
					state_q <= ST_PMY;
				end
				ST_PMY: begin
					if (pv_q) begin
						acc_x_q <= acc_x_q + prod_ext_c;
					end
					state_q <= ST_PMZ;
				end
				ST_PMZ: begin
					if (pv_q) begin
						acc_y_q <= acc_y_q + prod_ext_c;
					end
					state_q <= ST_PACC;
				end
				ST_PACC: begin
					if (pv_q) begin
						acc_z_q <= acc_z_q + prod_ext_c;
					end
					if (i_q == JW'(d_c)) begin
						state_q <= ST_FIN;
					end else begin
						i_q     <= i_q + JW'(1);
						state_q <= ST_PRD;
					end
				end

				// Hold until the output register is free, then round and saturate
				ST_FIN: begin
					if (fin_go_c) begin
						out_ch.curve_x    <= fin_coord(acc_x_q);
						out_ch.curve_y    <= fin_coord(acc_y_q);
						out_ch.curve_z    <= fin_coord(acc_z_q);
						out_ch.span_index <= bspc_pkg::SPAN_W'(span_q);
						state_q           <= ST_IDLE;
					end
				end

				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* hdl/bspc_checker.sv */
// Port-level checker for the curve evaluator, bound to the top level.
// Depends on bspc_pkg and bspline_curve_point_evaluator_unit_macros.svh.
`include "bspline_curve_point_evaluator_unit_macros.svh"

module bspc_checker (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic [bspc_pkg::ACTION_W-1:0] in_action,
	input logic                    out_valid,
	input logic                    out_ready
);

	// A pending result holds until taken
	`BSPC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	// An evaluate request occupies the block
	`BSPC_ASSERT_NEXT(a_eval_busy, clk, arst_n, in_valid && in_ready && in_action == bspc_pkg::ACT_EVAL, !in_ready)
	// Loads never stall the request side
	`BSPC_ASSERT_NEXT(a_load_free, clk, arst_n, in_valid && in_ready && in_action != bspc_pkg::ACT_EVAL, in_ready)
	// A new result only ever follows a busy cycle
	`BSPC_ASSERT_SAME(a_out_after_work, clk, arst_n, $rose(out_valid), $past(!in_ready))

endmodule

bind bspline_curve_point_evaluator_unit bspc_checker u_bspc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_action (in_ch.action),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready)
);

/* verif/testbench.sv */
// Self-checking bench for the B-spline curve point evaluator: knot and point loads, then
// evaluations under several degree/last-point settings, checked against a built-in predictor.
// Depends on bspc_pkg, the channel interfaces in bspc_ifs.sv and the evaluator unit.
`timescale 1ns / 1ps
module testbench;

	localparam int NPTS       = 64;
	localparam int KNOT_DEPTH = 68;
	localparam int FRACB      = 16;
	localparam longint BASIS_LIM = longint'(1) << (FRACB + 4);
	// no function, must be ignored
	localparam logic [bspc_pkg::ACTION_W-1:0] ACT_SPARE = 2'd3;
	localparam int T_ONE      = 65536;

	typedef struct {
		bspc_pkg::action_t action;
		bspc_pkg::slot_t   slot;
		bspc_pkg::knot_t   knot_value;
		bspc_pkg::coord_t  px;
		bspc_pkg::coord_t  py;
		bspc_pkg::coord_t  pz;
		bspc_pkg::knot_t   t;
	} curve_req_t;

	typedef struct {
		bspc_pkg::coord_t x;
		bspc_pkg::coord_t y;
		bspc_pkg::coord_t z;
		bspc_pkg::span_t  span;
	} curve_pt_t;

	logic clk;
	logic arst_n;

	bspc_in_if  in_ch();
	bspc_out_if out_ch();
	bspc_cfg_if cfg_ch();

	bspline_curve_point_evaluator_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	// Predictor state, mirrored at every accepted request and register write
	bspc_pkg::knot_t  knot_mem [KNOT_DEPTH];
	bspc_pkg::coord_t px_mem [NPTS];
	bspc_pkg::coord_t py_mem [NPTS];
	bspc_pkg::coord_t pz_mem [NPTS];
	int unsigned cur_degree = bspc_pkg::DEGREE_RST;
	int unsigned cur_last   = bspc_pkg::LAST_RST;

	curve_req_t pending_reqs[$];
	curve_pt_t  expected_pts[$];
	curve_req_t in_flight;
	int         mismatches = 0;
	bit         gaps_on = 1'b1;
	int         in_gap = 0;
	int         out_gap = 0;
	int         cyc = 0;

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (!gaps_on || r < 13) return 0;
		if (r < 18) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic longint knot_at(int unsigned i);
		return (i < KNOT_DEPTH) ? longint'(knot_mem[i]) : 0;
	endfunction

	function automatic longint clamp_basis(longint v);
		if (v > BASIS_LIM) return BASIS_LIM;
		if (v < -BASIS_LIM) return -BASIS_LIM;
		return v;
	endfunction

	// Round half away from zero by the fraction bits, then saturate to 32 bits
	function automatic bspc_pkg::coord_t round_sat(longint acc);
		bit     neg;
		longint mag;
		longint v;
		neg = acc < 0;
		mag = neg ? -acc : acc;
		mag = (mag + (longint'(1) << (FRACB - 1))) >>> FRACB;
		v = neg ? -mag : mag;
		if (v > 64'sd2147483647) v = 64'sd2147483647;
		if (v < -64'sd2147483648) v = -64'sd2147483648;
		return bspc_pkg::coord_t'(v);
	endfunction

	function automatic curve_pt_t eval_curve(bspc_pkg::knot_t t_in);
		int unsigned d, lo, hi, mid, sp, k, j, r;
		longint tv, den, a, b, saved, ax, ay, az;
		longint lft[4];
		longint rgt[4];
		longint bas[4];
		curve_pt_t res;
		d = cur_degree;
		tv = longint'(t_in);
		lo = d;
		hi = cur_last + 1;
		// binary search for the span, plain less-than against the knot
		while (hi > lo + 1) begin
			mid = (hi + lo) >> 1;
			if (tv < knot_at(mid)) hi = mid;
			else lo = mid;
		end
		sp = lo;
		for (int i = 0; i < 4; i++) begin
			lft[i] = 0;
			rgt[i] = 0;
			bas[i] = 0;
		end
		bas[0] = longint'(1) << FRACB;
		for (j = 1; j <= d; j++) begin
			saved = 0;
			lft[j] = tv - knot_at(sp + 1 - j);
			rgt[j] = knot_at(sp + j) - tv;
			for (r = 0; r < j; r++) begin
				den = rgt[r+1] + lft[j-r];
				a = 0;
				b = 0;
				// repeated knots: a zero denominator drops both terms
				if (den != 0) begin
					a = bas[r] * rgt[r+1] / den;
					b = bas[r] * lft[j-r] / den;
				end
				bas[r] = clamp_basis(saved + a);
				saved = clamp_basis(b);
			end
			bas[j] = saved;
		end
		ax = 0;
		ay = 0;
		az = 0;
		for (int i = 0; i <= d; i++) begin
			k = sp - d + i;
			if (k < NPTS) begin
				ax += longint'(px_mem[k]) * bas[i];
				ay += longint'(py_mem[k]) * bas[i];
				az += longint'(pz_mem[k]) * bas[i];
			end
		end
		res.x = round_sat(ax);
		res.y = round_sat(ay);
		res.z = round_sat(az);
		res.span = bspc_pkg::span_t'(sp);
		return res;
	endfunction

	// Mirror one accepted request into the predictor
	function automatic void apply_req(curve_req_t q);
		case (q.action)
			bspc_pkg::ACT_LOAD_KNOT: begin
				if (q.slot < KNOT_DEPTH) knot_mem[q.slot] = q.knot_value;
			end
			bspc_pkg::ACT_LOAD_POINT: begin
				if (q.slot < NPTS) begin
					px_mem[q.slot] = q.px;
					py_mem[q.slot] = q.py;
					pz_mem[q.slot] = q.pz;
				end
			end
			bspc_pkg::ACT_EVAL: expected_pts.insert(expected_pts.size(), eval_curve(q.t));
			default: ;
		endcase
	endfunction

	// Request driver: offer the next pending request, hold it until taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_gap <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) apply_req(in_flight);
			if (!in_ch.valid || in_ch.ready) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					in_ch.valid <= 1'b0;
				end else if (pending_reqs.size() > 0) begin
					in_flight = pending_reqs.pop_front();
					in_ch.action     <= in_flight.action;
					in_ch.slot       <= in_flight.slot;
					in_ch.knot_value <= in_flight.knot_value;
					in_ch.point_x    <= in_flight.px;
					in_ch.point_y    <= in_flight.py;
					in_ch.point_z    <= in_flight.pz;
					in_ch.param_t    <= in_flight.t;
					in_ch.valid      <= 1'b1;
					in_gap <= pick_gap();
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor and receiver back-pressure; a long hold-off window fills the block
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			out_gap <= 0;
			cyc <= 0;
		end else begin
			cyc <= cyc + 1;
			if (out_ch.valid && out_ch.ready) begin
				if (expected_pts.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result x=%0d y=%0d z=%0d span=%0d",
							out_ch.curve_x, out_ch.curve_y, out_ch.curve_z,
							out_ch.span_index);
				end else begin
					curve_pt_t e;
					e = expected_pts.pop_front();
					if (e.x !== out_ch.curve_x || e.y !== out_ch.curve_y ||
							e.z !== out_ch.curve_z || e.span !== out_ch.span_index) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch: exp x=%0d y=%0d z=%0d span=%0d,",
								" got x=%0d y=%0d z=%0d span=%0d"},
								e.x, e.y, e.z, e.span, out_ch.curve_x, out_ch.curve_y,
								out_ch.curve_z, out_ch.span_index);
					end
				end
			end
			if (cyc >= 3000 && cyc < 6000) begin
				out_ch.ready <= 1'b0;
			end else if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				out_gap <= pick_gap();
			end
		end
	end

	function automatic curve_req_t blank_req();
		curve_req_t q;
		q.action = bspc_pkg::ACT_EVAL;
		q.slot = '0;
		q.knot_value = '0;
		q.px = '0;
		q.py = '0;
		q.pz = '0;
		q.t = '0;
		return q;
	endfunction

	task automatic push_knot(int s, int v);
		curve_req_t q;
		q = blank_req();
		q.action = bspc_pkg::ACT_LOAD_KNOT;
		q.slot = bspc_pkg::slot_t'(s);
		q.knot_value = bspc_pkg::knot_t'(v);
		pending_reqs.insert(pending_reqs.size(), q);
	endtask

	task automatic push_point(int s, bspc_pkg::coord_t x, bspc_pkg::coord_t y,
			bspc_pkg::coord_t z);
		curve_req_t q;
		q = blank_req();
		q.action = bspc_pkg::ACT_LOAD_POINT;
		q.slot = bspc_pkg::slot_t'(s);
		q.px = x;
		q.py = y;
		q.pz = z;
		pending_reqs.insert(pending_reqs.size(), q);
	endtask

	task automatic push_eval(int tv);
		curve_req_t q;
		q = blank_req();
		q.t = bspc_pkg::knot_t'(tv);
		pending_reqs.insert(pending_reqs.size(), q);
	endtask

	function automatic bspc_pkg::coord_t rand_coord();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 32'sh7fffffff;
		if (r == 1) return 32'sh80000000;
		if (r < 5) return bspc_pkg::coord_t'($urandom);
		return bspc_pkg::coord_t'($urandom_range(0, 32'h00ffffff)) - 32'sh00800000;
	endfunction

	// Clamped, non-decreasing knot vector with the odd repeated knot
	task automatic push_knot_vector(int d, int lastp);
		int prev, v, room;
		prev = 0;
		for (int i = 0; i <= lastp + d + 1 && i < KNOT_DEPTH; i++) begin
			if (i <= d) v = 0;
			else if (i > lastp) v = T_ONE;
			else if ($urandom_range(0, 5) == 0) v = prev;
			else begin
				room = (T_ONE - prev) / (lastp + 2 - i);
				v = prev + $urandom_range(0, 2 * room);
				if (v > T_ONE) v = T_ONE;
			end
			push_knot(i, v);
			prev = v;
		end
	endtask

	// Wait until nothing is in flight, then let trailing loads settle
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_reqs.size() != 0 || expected_pts.size() != 0 || in_ch.valid);
		repeat (50) @(negedge clk);
	endtask

	task automatic write_reg(bspc_pkg::cfg_idx_t idx, int val);
		@(posedge clk);
		cfg_ch.index <= idx;
		cfg_ch.data  <= bspc_pkg::cfg_data_t'(val);
		cfg_ch.valid <= 1'b1;
		do @(negedge clk);
		while (!cfg_ch.ready);
		@(posedge clk);
		cfg_ch.valid <= 1'b0;
		if (idx == bspc_pkg::CFG_DEGREE) cur_degree = val;
		else cur_last = val;
	endtask

	task automatic push_random(int lastp, int d);
		curve_req_t q;
		int r;
		r = $urandom_range(0, 99);
		q = blank_req();
		if (r < 15) begin
			// noise: any action, slot and coordinates; knot value and parameter in 0..T_ONE
			q.action = bspc_pkg::action_t'($urandom_range(0, 3));
			q.slot = bspc_pkg::slot_t'($urandom_range(0, 127));
			q.knot_value = bspc_pkg::knot_t'($urandom_range(0, T_ONE));
			q.px = bspc_pkg::coord_t'($urandom);
			q.py = bspc_pkg::coord_t'($urandom);
			q.pz = bspc_pkg::coord_t'($urandom);
			q.t = bspc_pkg::knot_t'($urandom_range(0, T_ONE));
			pending_reqs.insert(pending_reqs.size(), q);
		end else if (r < 65) begin
			r = $urandom_range(0, 7);
			if (r == 0) push_eval(0);
			else if (r == 1) push_eval(T_ONE);
			else if (r == 2) push_eval(knot_mem[$urandom_range(0, lastp + d)]);
			else push_eval($urandom_range(0, T_ONE));
		end else if (r < 88) begin
			push_point($urandom_range(0, NPTS - 1), rand_coord(), rand_coord(), rand_coord());
		end else begin
			// interior knot kept between its neighbours
			int s, lo, hi;
			s = $urandom_range(1, lastp + d);
			lo = knot_mem[s-1];
			hi = knot_mem[s+1];
			if (hi < lo) hi = lo;
			push_knot(s, $urandom_range(lo, hi));
		end
	endtask

	int phase_deg [8] = '{3, 0, 1, 2, 3, 3, 0, 2};
	int phase_last[8] = '{3, 1, 5, 63, 63, 1, 63, 10};

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.action = bspc_pkg::ACT_LOAD_KNOT;
		in_ch.slot = '0;
		in_ch.knot_value = '0;
		in_ch.point_x = '0;
		in_ch.point_y = '0;
		in_ch.point_z = '0;
		in_ch.param_t = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = bspc_pkg::CFG_DEGREE;
		cfg_ch.data = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Write every store entry once so no evaluation reads an unwritten one
		for (int i = 0; i < KNOT_DEPTH; i++) push_knot(i, (i < 4) ? 0 : (i > 3 ? T_ONE : 0));
		for (int i = 0; i < NPTS; i++) push_point(i, rand_coord(), rand_coord(), rand_coord());

		// Directed: field extremes, repeated knots, ignored loads and the spare action
		push_knot(4, T_ONE);
		push_knot(127, T_ONE);
		push_knot(KNOT_DEPTH, 0);
		push_point(127, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
		push_point(NPTS, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		push_point(0, 32'sh7fffffff, 32'sh80000000, 0);
		push_point(3, 32'sh80000000, 32'sh7fffffff, -1);
		push_eval(0);
		push_eval(T_ONE);
		push_eval(T_ONE - 1);
		push_eval(32768);
		push_knot(2, 30000);
		push_knot(3, 20000);
		push_eval(25000);
		push_eval(30000);
		begin
			curve_req_t q;
			q = blank_req();
			q.action = ACT_SPARE;
			q.slot = 7'h7f;
			q.knot_value = bspc_pkg::knot_t'(T_ONE);
			q.t = bspc_pkg::knot_t'(T_ONE);
			pending_reqs.insert(pending_reqs.size(), q);
		end
		push_knot(2, 0);
		push_knot(3, 0);
		push_eval(1);

		for (int p = 0; p < 8; p++) begin
			// sender pauses here until every outstanding result has come back
			wait_drained();
			write_reg(bspc_pkg::CFG_DEGREE, phase_deg[p]);
			write_reg(bspc_pkg::CFG_LAST_POINT, phase_last[p]);
			gaps_on = (p % 3) != 2;
			push_knot_vector(phase_deg[p], phase_last[p]);
			// wait for the vector to land before basing random knots on it
			do @(negedge clk);
			while (pending_reqs.size() != 0 || in_ch.valid);
			for (int n = 0; n < 70; n++) push_random(phase_last[p], phase_deg[p]);
		end

		wait_drained();
		repeat (400) @(posedge clk);
		if (mismatches == 0 && expected_pts.size() == 0) begin
			$display("bspline_curve_point_evaluator_unit verification clean");
		end else begin
			$display("bspline_curve_point_evaluator_unit verification failed");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("bspline_curve_point_evaluator_unit verification failed");
		$finish;
	end

endmodule
